FILE: src/assert_macros.svh
// Assertion macros for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/prlud_pkg.sv
package prlud_pkg;

  localparam int MAX_RAW      = 4096;
  localparam int UID_MAX_BITS = 224;
  localparam int MAX_SAMPLES  = 65536;
  localparam int SHORT_LEN    = 64;
  localparam int SHORT_SYNC   = 29;
  localparam int LONG_SYNC    = 30;

  localparam logic [1:0] PH_RISE = 2'd0;
  localparam logic [1:0] PH_FALL = 2'd1;
  localparam logic [1:0] PH_NONE = 2'd2;

  localparam logic [1:0] ST_UID_FOUND = 2'd0;
  localparam logic [1:0] ST_NO_RAW    = 2'd1;
  localparam logic [1:0] ST_NO_SYNC   = 2'd2;
  localparam logic [1:0] ST_PARTIAL   = 2'd3;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_WORD    = 1'b1;

  typedef struct packed {
    logic        has_run;
    logic        bit_val;
    logic [12:0] nbits;
    logic        is_end;
    logic [15:0] worst;
    logic [15:0] worst_at;
  } run_entry_t;

endpackage

FILE: src/prlud_front.sv
module prlud_front
  import prlud_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic signed [7:0] in_sample_first,
  input  logic signed [7:0] in_sample_second,
  input  logic             in_end_of_capture,
  input  logic             q_full,
  output logic             q_wr,
  output run_entry_t       q_entry
);

  localparam logic [15:0] POS_SAT = 16'(MAX_SAMPLES - 2);

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt, cnt_inc;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] worst_r, worst_nxt, worst_at_r, worst_at_nxt;
  logic [16:0] nb17, full17, res17;
  logic        close, bit_v, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    cnt_inc = (cnt_r != 16'hFFFF) ? cnt_r + 16'd1 : cnt_r;
    nb17    = ({1'b0, cnt_inc} + 17'd7) >> 4;
    full17  = nb17 << 4;
    res17   = (full17 >= {1'b0, cnt_inc}) ? full17 - {1'b0, cnt_inc}
                                          : {1'b0, cnt_inc} - full17;
    close     = 1'b0;
    bit_v     = 1'b0;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_inc;
    if (in_sample_first > in_sample_second && phase_r != PH_FALL) begin
      close     = (phase_r == PH_RISE);
      bit_v     = 1'b0;
      phase_nxt = PH_FALL;
      cnt_nxt   = '0;
    end else if (in_sample_first < in_sample_second && phase_r != PH_RISE) begin
      close     = (phase_r == PH_FALL);
      bit_v     = 1'b1;
      phase_nxt = PH_RISE;
      cnt_nxt   = '0;
    end
    worst_nxt    = worst_r;
    worst_at_nxt = worst_at_r;
    if (close && res17[15:0] > worst_r) begin
      worst_nxt    = res17[15:0];
      worst_at_nxt = pos_r;
    end
    pos_nxt = (pos_r < POS_SAT) ? pos_r + 16'd2 : pos_r;

    q_entry.has_run  = close;
    q_entry.bit_val  = bit_v;
    q_entry.nbits    = nb17[12:0];
    q_entry.is_end   = in_end_of_capture;
    q_entry.worst    = worst_nxt;
    q_entry.worst_at = worst_at_nxt;
    q_wr = accept && (close || in_end_of_capture);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_end_of_capture)) begin
      phase_r    <= PH_NONE;
      cnt_r      <= '0;
      pos_r      <= '0;
      worst_r    <= '0;
      worst_at_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      pos_r      <= pos_nxt;
      worst_r    <= worst_nxt;
      worst_at_r <= worst_at_nxt;
    end
  end

endmodule

FILE: src/prlud_queue.sv
module prlud_queue
  import prlud_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr,
  input  run_entry_t wr_data,
  output logic       full,
  input  logic       rd,
  output logic       valid,
  output run_entry_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  run_entry_t      mem [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr && !full) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (rd && valid) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(wr && !full) - (AW+1)'(rd && valid);
    end
  end

endmodule

FILE: src/prlud_back.sv
module prlud_back
  import prlud_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        uid_long,
  input  logic        q_valid,
  input  run_entry_t  q_entry,
  output logic        q_rd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [1:0]  out_status,
  output logic [12:0] out_raw_bit_count,
  output logic        out_overflowed,
  output logic [15:0] out_worst_metric,
  output logic [15:0] out_worst_position,
  output logic [11:0] out_sync_start,
  output logic [12:0] out_occurrences,
  output logic [1:0]  out_word_index,
  output logic [63:0] out_uid_word,
  output logic        out_last_result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BITS = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic [12:0]  rem_r, rem_nxt;
  logic         v_r, v_nxt, end_r, end_nxt;
  logic [15:0]  fw_r, fw_nxt, fwa_r, fwa_nxt;
  logic [12:0]  raw_r, raw_nxt;
  logic         ovf_r, ovf_nxt;
  logic         rv_r, rv_nxt;
  logic [4:0]   rl_r, rl_nxt;
  logic [11:0]  rb_r, rb_nxt;
  logic         sync_r, sync_nxt, inv_r, inv_nxt;
  logic [255:0] head_r, head_nxt, uid_r, uid_nxt;
  logic [7:0]   chunk_r, chunk_nxt, ce, c1;
  logic [12:0]  rep_r, rep_nxt;
  logic         match_r, match_nxt;
  logic [2:0]   item_r, item_nxt;
  logic         clear, load, b;
  logic [7:0]   len8;
  logic [4:0]   sync_len;
  logic [1:0]   st;
  logic [2:0]   nwords;
  logic [1:0]   w;
  logic [255:0] src;
  logic [63:0]  word;

  logic        ov_r, ok_r, olast_r;
  logic [1:0]  ost_r, owi_r;
  logic [12:0] oraw_r, oocc_r;
  logic        oovf_r;
  logic [15:0] ofw_r, ofwa_r;
  logic [11:0] oss_r;
  logic [63:0] ouid_r;

  assign len8     = uid_long ? 8'(UID_MAX_BITS) : 8'(SHORT_LEN);
  assign sync_len = uid_long ? 5'(LONG_SYNC) : 5'(SHORT_SYNC);
  assign q_rd     = (state_r == S_IDLE) && q_valid;
  assign load     = (state_r == S_EMIT) && (!ov_r || !out_stall);

  always_comb begin
    if (raw_r == '0) begin
      st = ST_NO_RAW;
    end else if (raw_r < {5'd0, len8}) begin
      st = ST_PARTIAL;
    end else if (sync_r && rep_r != '0) begin
      st = ST_UID_FOUND;
    end else begin
      st = ST_NO_SYNC;
    end
    nwords = (st == ST_UID_FOUND || st == ST_PARTIAL) ? (uid_long ? 3'd4 : 3'd1) : 3'd0;
    w      = 2'(item_r - 3'd1);
    src    = (st == ST_PARTIAL) ? head_r : uid_r;
    word   = 64'(src >> {~w, 6'd0});
    if (item_r == nwords && uid_long) begin
      word = word >> 32;
    end
    clear = load && (item_r == nwords);
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    v_nxt     = v_r;
    end_nxt   = end_r;
    fw_nxt    = fw_r;
    fwa_nxt   = fwa_r;
    raw_nxt   = raw_r;
    ovf_nxt   = ovf_r;
    rv_nxt    = rv_r;
    rl_nxt    = rl_r;
    rb_nxt    = rb_r;
    sync_nxt  = sync_r;
    inv_nxt   = inv_r;
    head_nxt  = head_r;
    uid_nxt   = uid_r;
    chunk_nxt = chunk_r;
    rep_nxt   = rep_r;
    match_nxt = match_r;
    item_nxt  = item_r;
    b         = v_r ^ inv_r;
    ce        = (chunk_r >= len8) ? 8'd0 : chunk_r;
    c1        = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          rem_nxt = q_entry.has_run ? q_entry.nbits : 13'd0;
          v_nxt   = q_entry.bit_val;
          end_nxt = q_entry.is_end;
          fw_nxt  = q_entry.worst;
          fwa_nxt = q_entry.worst_at;
          if (q_entry.has_run && q_entry.nbits != '0) begin
            state_nxt = S_BITS;
          end else if (q_entry.is_end) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_BITS: begin
        rem_nxt = rem_r - 13'd1;
        if (rem_r == 13'd1) begin
          state_nxt = end_r ? S_EMIT : S_IDLE;
        end
        if (raw_r >= 13'(MAX_RAW)) begin
          ovf_nxt = 1'b1;
        end else begin
          raw_nxt = raw_r + 13'd1;
          if (raw_r < 13'(UID_MAX_BITS)) begin
            head_nxt[~raw_r[7:0]] = v_r;
          end
          if (!sync_r) begin
            if (rl_r == '0 || v_r != rv_r) begin
              rv_nxt = v_r;
              rl_nxt = 5'd1;
              rb_nxt = raw_r[11:0];
            end else if (rl_r != 5'd31) begin
              rl_nxt = rl_r + 5'd1;
            end
            if (rl_nxt >= sync_len) begin
              sync_nxt  = 1'b1;
              inv_nxt   = rv_nxt;
              chunk_nxt = {3'd0, rl_nxt};
            end
          end else if (rep_r == '0) begin
            uid_nxt[~chunk_r] = b;
            c1 = chunk_r + 8'd1;
            if (c1 >= len8) begin
              rep_nxt   = 13'd1;
              chunk_nxt = '0;
            end else begin
              chunk_nxt = c1;
            end
          end else if (match_r) begin
            chunk_nxt = ce;
            if (uid_r[~ce] != b) begin
              match_nxt = 1'b0;
            end else begin
              c1 = ce + 8'd1;
              if (c1 >= len8) begin
                if (rep_r != 13'h1FFF) begin
                  rep_nxt = rep_r + 13'd1;
                end
                chunk_nxt = '0;
              end else begin
                chunk_nxt = c1;
              end
            end
          end
        end
      end
      S_EMIT: begin
        if (load) begin
          item_nxt = item_r + 3'd1;
          if (clear) begin
            state_nxt = S_IDLE;
            item_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      state_r <= S_IDLE;
      raw_r   <= '0;
      ovf_r   <= 1'b0;
      rv_r    <= 1'b0;
      rl_r    <= '0;
      rb_r    <= '0;
      sync_r  <= 1'b0;
      inv_r   <= 1'b0;
      head_r  <= '0;
      uid_r   <= '0;
      chunk_r <= '0;
      rep_r   <= '0;
      match_r <= 1'b1;
      item_r  <= '0;
      end_r   <= 1'b0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      raw_r   <= raw_nxt;
      ovf_r   <= ovf_nxt;
      rv_r    <= rv_nxt;
      rl_r    <= rl_nxt;
      rb_r    <= rb_nxt;
      sync_r  <= sync_nxt;
      inv_r   <= inv_nxt;
      head_r  <= head_nxt;
      uid_r   <= uid_nxt;
      chunk_r <= chunk_nxt;
      rep_r   <= rep_nxt;
      match_r <= match_nxt;
      item_r  <= item_nxt;
      end_r   <= end_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    fw_r  <= fw_nxt;
    fwa_r <= fwa_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (item_r == '0) begin
        ok_r    <= KIND_SUMMARY;
        ost_r   <= st;
        oraw_r  <= raw_r;
        oovf_r  <= ovf_r;
        ofw_r   <= fw_r;
        ofwa_r  <= fwa_r;
        oss_r   <= (st == ST_UID_FOUND) ? rb_r : 12'd0;
        oocc_r  <= (st == ST_UID_FOUND) ? rep_r : 13'd0;
        owi_r   <= '0;
        ouid_r  <= '0;
      end else begin
        ok_r    <= KIND_WORD;
        ost_r   <= ST_UID_FOUND;
        oraw_r  <= '0;
        oovf_r  <= 1'b0;
        ofw_r   <= '0;
        ofwa_r  <= '0;
        oss_r   <= '0;
        oocc_r  <= '0;
        owi_r   <= w;
        ouid_r  <= word;
      end
      olast_r <= (item_r == nwords);
    end
  end

  assign out_valid          = ov_r;
  assign out_item_kind      = ok_r;
  assign out_status         = ost_r;
  assign out_raw_bit_count  = oraw_r;
  assign out_overflowed     = oovf_r;
  assign out_worst_metric   = ofw_r;
  assign out_worst_position = ofwa_r;
  assign out_sync_start     = oss_r;
  assign out_occurrences    = oocc_r;
  assign out_word_index     = owi_r;
  assign out_uid_word       = ouid_r;
  assign out_last_result    = olast_r;

endmodule

FILE: src/psk_run_length_uid_demodulator_unit.sv
// PSK run-length demodulator with UID capture. Each input word is a sample pair;
// the front stage takes one pair per cycle while the queue is not full and posts
// each closed run and the end marker to a small queue. The back stage picks up a
// queued entry and then expands a run into raw bits at one bit per cycle (about 16
// pairs per bit); the queue absorbs bursts and the input stalls only when it fills.
// After the end-of-capture pair, the back stage drains its bits and then emits one
// summary word, followed by one or four UID words when a full or partial UID is
// reported, one per cycle as the output accepts them. uid_long must be written only
// while the block is idle; the block itself does not enforce this.
module psk_run_length_uid_demodulator_unit
  import prlud_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic signed [7:0] in_sample_first,
  input  logic signed [7:0] in_sample_second,
  input  logic             in_end_of_capture,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_item_kind,
  output logic [1:0]       out_status,
  output logic [12:0]      out_raw_bit_count,
  output logic             out_overflowed,
  output logic [15:0]      out_worst_metric,
  output logic [15:0]      out_worst_position,
  output logic [11:0]      out_sync_start,
  output logic [12:0]      out_occurrences,
  output logic [1:0]       out_word_index,
  output logic [63:0]      out_uid_word,
  output logic             out_last_result
);

  logic       uid_long_r;
  logic       q_full, q_wr, q_rd, q_valid;
  run_entry_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uid_long_r <= 1'b0;
    end else if (cfg_we) begin
      uid_long_r <= cfg_wdata;
    end
  end

  prlud_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_first   (in_sample_first),
    .in_sample_second  (in_sample_second),
    .in_end_of_capture (in_end_of_capture),
    .q_full            (q_full),
    .q_wr              (q_wr),
    .q_entry           (q_wdata)
  );

  prlud_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_rd),
    .valid   (q_valid),
    .rd_data (q_rdata)
  );

  prlud_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .uid_long           (uid_long_r),
    .q_valid            (q_valid),
    .q_entry            (q_rdata),
    .q_rd               (q_rd),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_status         (out_status),
    .out_raw_bit_count  (out_raw_bit_count),
    .out_overflowed     (out_overflowed),
    .out_worst_metric   (out_worst_metric),
    .out_worst_position (out_worst_position),
    .out_sync_start     (out_sync_start),
    .out_occurrences    (out_occurrences),
    .out_word_index     (out_word_index),
    .out_uid_word       (out_uid_word),
    .out_last_result    (out_last_result)
  );

endmodule

FILE: src/prlud_checker.sv
`include "assert_macros.svh"

module prlud_checker
  import prlud_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_item_kind,
  input logic [1:0]  out_status,
  input logic [12:0] out_occurrences,
  input logic [63:0] out_uid_word,
  input logic        out_last_result
);

  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")
  `CHK_NOW(a_noraw_last, out_valid && out_item_kind == KIND_SUMMARY && out_status == ST_NO_RAW, out_last_result, "empty capture must end the burst")
  `CHK_NOW(a_word_clean, out_valid && out_item_kind == KIND_WORD, out_status == ST_UID_FOUND && out_occurrences == '0, "word item carries summary fields")
  `CHK_NOW(a_sum_clean, out_valid && out_item_kind == KIND_SUMMARY, out_uid_word == '0, "summary item carries UID bits")

endmodule

bind psk_run_length_uid_demodulator_unit prlud_checker u_prlud_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_item_kind   (out_item_kind),
  .out_status      (out_status),
  .out_occurrences (out_occurrences),
  .out_uid_word    (out_uid_word),
  .out_last_result (out_last_result)
);
